// ===== hw/rtl/psramcwd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psramcwd_pkg
// Shared types and constants of the PSRAM command word decoder.
// ----------------------------------------------------------------------------
package psramcwd_pkg;

  // Command byte codes (top byte of the command word)
  localparam logic [7:0] CMD_QUAD  = 8'h35;
  localparam logic [7:0] CMD_WRITE = 8'h38;
  localparam logic [7:0] CMD_READ  = 8'hEB;

  // State machine numbers
  localparam logic [1:0] MACH_MEM = 2'd0;
  localparam logic [1:0] MACH_SD  = 2'd1;

  localparam int WORD_W   = 32;
  localparam int ADDR_W   = 24;  // width of the stored address and output field
  localparam int BYTES_PER_WORD = 4;

  // Per-bank transaction parser state
  typedef struct packed {
    logic [27:0] words;     // transaction length in words
    logic [31:0] pos;       // word position, wraps mod 2^32
    logic [28:0] dlen;      // data length in bytes
    logic        quad;      // quad mode enabled
    logic [7:0]  last_cmd;  // last command byte
    logic [23:0] taddr;     // transfer start address
  } bank_state_t;

  // Byte writes produced by one memory-link word
  typedef struct packed {
    logic [2:0]  count;     // 0..4 byte writes
    logic [23:0] base;      // address of the first byte write
  } decode_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/psramcwd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psramcwd_if
// Valid/ready channels: transmit words in, byte writes / RX fills out.
// ----------------------------------------------------------------------------
interface psramcwd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] tx_word;
  logic [1:0]  machine_number;
  logic        bank_select;

  modport source(output valid, tx_word, machine_number, bank_select, input ready);
  modport sink(input valid, tx_word, machine_number, bank_select, output ready);
endinterface

interface psramcwd_out_if;
  logic        valid;
  logic        ready;
  logic        rx_fill;
  logic        write_bank;
  logic [23:0] write_address;
  logic [7:0]  write_byte;
  logic        last;

  modport source(output valid, rx_fill, write_bank, write_address, write_byte, last,
                 input ready);
  modport sink(input valid, rx_fill, write_bank, write_address, write_byte, last,
               output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/psram_command_word_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psram_command_word_decoder_core
// Snoops serial-memory transmit words and turns PSRAM write transactions into
// byte writes; SD-link words give an RX-fill request.
// ----------------------------------------------------------------------------
// Timing: a word is registered on transfer, decoded against its bank's state
// while it sits in the input register and its results loaded into the output
// register once that is free. The output register gives one result per cycle
// while out_ch is ready: a write data word holds it until all its byte writes
// (up to four) have transferred, an SD-link word until its one RX fill has.
// Words that give no result (length, command, address, reads, other machines)
// go through at one per cycle, even while earlier results wait on out_ch.
// Each bank's parser state updates in the decode cycle, so consecutive words
// to the same bank follow back to back. Output fields are all registered.
// ----------------------------------------------------------------------------
module psram_command_word_decoder_core #(
  parameter int BANK_COUNT   = 2,
  parameter int ADDRESS_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  psramcwd_in_if.sink      in_ch,
  psramcwd_out_if.source   out_ch
);
  import psramcwd_pkg::*;

  localparam logic [2:0] BANK_LIM = 3'(BANK_COUNT);

  // input register
  logic        v1_r;
  logic [31:0] word1_r;
  logic [1:0]  mach1_r;
  logic        bank1_r;

  // bank state
  bank_state_t st_r [BANK_COUNT];
  bank_state_t cur;
  bank_state_t st_nxt;
  decode_res_t res;

  // output register
  logic [2:0]              rem_r;   // results left for the current word
  logic                    rx_r;
  logic                    bank_r;
  logic [ADDRESS_BITS-1:0] addr_r;
  logic [31:0]             data_r;  // byte to send sits in the top byte

  logic [1:0] bank_ext;
  logic       in_range;
  logic       is_mem;
  logic [2:0] load_cnt;
  logic       buf_free;
  logic       adv;
  logic       out_xfer;

  assign bank_ext = {1'b0, bank1_r};
  assign in_range = ({1'b0, bank_ext} < BANK_LIM);
  assign is_mem   = (mach1_r == MACH_MEM) && in_range;

  always_comb begin
    cur = st_r[0];
    for (int b = 0; b < BANK_COUNT; b++) begin
      if (bank_ext == 2'(b)) begin
        cur = st_r[b];
      end
    end
  end

  psramcwd_decode #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_decode (
    .word (word1_r),
    .cur  (cur),
    .nxt  (st_nxt),
    .res  (res)
  );

  always_comb begin
    if (mach1_r == MACH_SD) begin
      load_cnt = 3'd1;
    end else if (is_mem) begin
      load_cnt = res.count;
    end else begin
      load_cnt = 3'd0;
    end
  end

  assign out_xfer = (rem_r != 3'd0) && out_ch.ready;
  assign buf_free = (rem_r == 3'd0) || (out_ch.ready && rem_r == 3'd1);
  // words without results never wait on the output side
  assign adv      = v1_r && ((load_cnt == 3'd0) || buf_free);

  assign in_ch.ready = !v1_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      rem_r <= 3'd0;
      for (int b = 0; b < BANK_COUNT; b++) begin
        st_r[b] <= '0;
      end
    end else begin
      // input stage
      if (in_ch.valid && in_ch.ready) begin
        v1_r    <= 1'b1;
        word1_r <= in_ch.tx_word;
        mach1_r <= in_ch.machine_number;
        bank1_r <= in_ch.bank_select;
      end else if (adv) begin
        v1_r <= 1'b0;
      end

      // bank state update
      if (adv && is_mem) begin
        for (int b = 0; b < BANK_COUNT; b++) begin
          if (bank_ext == 2'(b)) begin
            st_r[b] <= st_nxt;
          end
        end
      end

      // output stage
      if (adv && load_cnt != 3'd0) begin
        rem_r <= load_cnt;
        if (mach1_r == MACH_SD) begin
          rx_r   <= 1'b1;
          bank_r <= 1'b0;
          addr_r <= '0;
          data_r <= '0;
        end else begin
          rx_r   <= 1'b0;
          bank_r <= bank1_r;
          addr_r <= ADDRESS_BITS'(res.base);
          data_r <= word1_r;
        end
      end else if (out_xfer) begin
        rem_r  <= rem_r - 3'd1;
        addr_r <= addr_r + ADDRESS_BITS'(1);
        data_r <= {data_r[23:0], 8'h00};
      end
    end
  end

  assign out_ch.valid         = (rem_r != 3'd0);
  assign out_ch.rx_fill       = rx_r;
  assign out_ch.write_bank    = bank_r;
  assign out_ch.write_address = 24'(addr_r);
  assign out_ch.write_byte    = data_r[31:24];
  assign out_ch.last          = (rem_r == 3'd1);

`ifndef SYNTH
  // a non-last transfer leaves the next byte of the same word at the next address
  a_byte_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && rem_r != 3'd1) |=>
      (rem_r != 3'd0) && addr_r == ADDRESS_BITS'($past(addr_r) + ADDRESS_BITS'(1)))
    else $error("byte write sequence broken");

  // an RX fill is always a single, final result with empty payload
  a_rx_single: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 3'd0 && rx_r) |-> (rem_r == 3'd1 && data_r == 32'd0))
    else $error("RX fill not a lone result");

  // input stalls only while a word waits in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && load_cnt != 3'd0 && rem_r != 3'd0))
    else $error("input stalled without cause");

  // never more than four results pending per word
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'(BYTES_PER_WORD))
    else $error("result count out of range");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/psramcwd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psramcwd_decode
// Parses one memory-link word against one bank's state: next state and the
// byte writes it produces.
// ----------------------------------------------------------------------------
module psramcwd_decode #(
  parameter int ADDRESS_BITS = 24
) (
  input  wire logic [31:0]               word,
  input  wire psramcwd_pkg::bank_state_t cur,
  output      psramcwd_pkg::bank_state_t nxt,
  output      psramcwd_pkg::decode_res_t res
);
  import psramcwd_pkg::*;

  logic [31:0] wp1;
  logic [31:0] pos_m3;
  logic [31:0] off;
  logic [31:0] diff;
  logic [7:0]  cmd;
  logic [ADDRESS_BITS-1:0] base_aw;

  assign wp1    = word + 32'd1;
  assign pos_m3 = cur.pos - 32'd3;
  assign off    = {pos_m3[29:0], 2'b00};         // (pos - 3) * 4
  assign diff   = {3'b000, cur.dlen} - off;
  assign cmd    = word[31:24];
  assign base_aw = ADDRESS_BITS'(cur.taddr) + ADDRESS_BITS'(off);

  always_comb begin
    nxt       = cur;
    res.count = 3'd0;
    res.base  = 24'(base_aw);
    if (cur.pos == {4'b0000, cur.words}) begin
      // length word
      if (cur.quad) begin
        nxt.words = 28'(wp1[29:3]) + 28'd4;
        nxt.dlen  = wp1[29:1];
      end else begin
        nxt.words = 28'(word[31:5]) + 28'd2;
        nxt.dlen  = wp1[31:3];
      end
      nxt.pos = 32'd1;
    end else begin
      nxt.pos = cur.pos + 32'd1;
      if (cur.pos == 32'd1) begin
        nxt.last_cmd = cmd;
        unique case (cmd)
          CMD_QUAD: begin
            nxt.quad = 1'b1;
          end
          CMD_WRITE: begin
            nxt.taddr = word[23:0];
          end
          CMD_READ: begin
            nxt.taddr = word[23:0];
            nxt.words = 28'd3;
          end
          default: begin
          end
        endcase
      end else if (cur.pos == 32'd2 && cur.quad) begin
        // address word in quad mode: nothing to do
      end else if (cur.last_cmd == CMD_WRITE) begin
        priority if (diff[31] || diff == 32'd0) begin
          res.count = 3'd0;
        end else if (diff >= 32'(BYTES_PER_WORD)) begin
          res.count = 3'(BYTES_PER_WORD);
        end else begin
          res.count = diff[2:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/psramcwd_write_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psramcwd_write_checker
// Passive checker for the PSRAM command word decoder. It keeps its own
// per-bank parser state, predicts the byte writes and RX fills of every word
// taken on in_ch, and compares each transfer on out_ch with the oldest
// prediction.
// ----------------------------------------------------------------------------
module psramcwd_write_checker
  import psramcwd_pkg::*;
#(
  parameter int BANK_COUNT   = 2,
  parameter int ADDRESS_BITS = 24
) (
  input  logic    clk,
  input  logic    rst_n,
  psramcwd_in_if  in_ch,
  psramcwd_out_if out_ch,
  output int      fail_count,
  output int      open_count
);

  typedef struct packed {
    logic        rx_fill;
    logic        bank;
    logic [23:0] addr;
    logic [7:0]  data;
    logic        last;
  } mem_op_t;

  localparam logic [31:0] ADDR_MASK = (32'd1 << ADDRESS_BITS) - 32'd1;

  mem_op_t     due_ops[$];
  logic [31:0] txn_words [BANK_COUNT];
  logic [31:0] txn_pos   [BANK_COUNT];
  logic [31:0] txn_bytes [BANK_COUNT];
  logic        quad_on   [BANK_COUNT];
  logic [7:0]  last_cmd  [BANK_COUNT];
  logic [23:0] base_addr [BANK_COUNT];
  int          fails;
  int          ops_seen;

  // Advance one bank's parser by one word and queue what it should emit.
  function automatic void decode_tx_word(logic [31:0] w, logic [1:0] mach, logic bank);
    logic [31:0] pos;
    logic [31:0] len;
    logic [31:0] dlen;
    logic [31:0] mult;
    logic [31:0] scaled;
    logic [31:0] off;
    logic [31:0] diff;
    logic [31:0] addr;
    int          nbytes;
    int          i;
    mem_op_t     op;
    if (mach == MACH_SD) begin
      op         = '0;
      op.rx_fill = 1'b1;
      op.last    = 1'b1;
      due_ops.push_back(op);
      return;
    end
    if (mach != MACH_MEM || int'(bank) >= BANK_COUNT) return;

    pos  = txn_pos[bank];
    len  = txn_words[bank];
    dlen = txn_bytes[bank];

    if (pos == len) begin
      // length word; sizes wrap at 32 bits
      pos    = '0;
      mult   = quad_on[bank] ? 32'd4 : 32'd1;
      scaled = (w + 32'd1) * mult;
      txn_words[bank] = quad_on[bank] ? scaled / 32'd32 + 32'd4 : w / 32'd32 + 32'd2;
      txn_bytes[bank] = scaled / 32'd8;
    end else if (pos == 32'd1) begin
      last_cmd[bank] = w[31:24];
      case (w[31:24])
        CMD_QUAD:  quad_on[bank] = 1'b1;
        CMD_WRITE: base_addr[bank] = w[23:0];
        CMD_READ: begin
          base_addr[bank] = w[23:0];
          txn_words[bank] = 32'd3;
        end
        default: ;
      endcase
    end else if (pos == 32'd2 && quad_on[bank]) begin
      // address word
    end else if (last_cmd[bank] == CMD_WRITE) begin
      off  = (pos - 32'd3) * 32'd4;
      diff = dlen - off;
      if (diff == 32'd0 || diff[31]) nbytes = 0;
      else if (diff >= 32'd4) nbytes = 4;
      else nbytes = int'(diff);
      for (i = 0; i < nbytes; i++) begin
        addr       = ({8'd0, base_addr[bank]} + off + 32'(i)) & ADDR_MASK;
        op.rx_fill = 1'b0;
        op.bank    = bank;
        op.addr    = addr[23:0];
        op.data    = w[31 - 8 * i -: 8];
        op.last    = (i == nbytes - 1);
        due_ops.push_back(op);
      end
    end

    txn_pos[bank] = pos + 32'd1;
  endfunction

  always @(posedge clk) begin : watch
    mem_op_t want;
    mem_op_t got;
    if (!rst_n) begin
      for (int b = 0; b < BANK_COUNT; b++) begin
        txn_words[b] = '0;
        txn_pos[b]   = '0;
        txn_bytes[b] = '0;
        quad_on[b]   = 1'b0;
        last_cmd[b]  = '0;
        base_addr[b] = '0;
      end
      due_ops.delete();
      fails    = 0;
      ops_seen = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        decode_tx_word(in_ch.tx_word, in_ch.machine_number, in_ch.bank_select);

      if (out_ch.valid && out_ch.ready) begin
        got.rx_fill = out_ch.rx_fill;
        got.bank    = out_ch.write_bank;
        got.addr    = out_ch.write_address;
        got.data    = out_ch.write_byte;
        got.last    = out_ch.last;
        if (due_ops.size() == 0) begin
          if (fails < 10) begin
            $display("[%0t] result %0d with nothing pending", $time, ops_seen);
            $display("  got  fill=%b bank=%b addr=%06h byte=%02h last=%b",
                     got.rx_fill, got.bank, got.addr, got.data, got.last);
          end
          fails++;
        end else begin
          want = due_ops.pop_front();
          if (got.rx_fill !== want.rx_fill || got.bank !== want.bank ||
              got.addr !== want.addr || got.data !== want.data || got.last !== want.last) begin
            if (fails < 10) begin
              $display("[%0t] result %0d wrong", $time, ops_seen);
              $display("  want fill=%b bank=%b addr=%06h byte=%02h last=%b",
                       want.rx_fill, want.bank, want.addr, want.data, want.last);
              $display("  got  fill=%b bank=%b addr=%06h byte=%02h last=%b",
                       got.rx_fill, got.bank, got.addr, got.data, got.last);
            end
            fails++;
          end
        end
        ops_seen++;
      end
    end
    fail_count <= fails;
    open_count <= due_ops.size();
  end

endmodule

// ===== tb/sv/tb_psram_command_word_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_psram_command_word_decoder_core
// Drives transmit words into the PSRAM command word decoder: a short directed
// run over length, command, address and data words on both banks, then
// interleaved random transactions mixed with SD-link and spare-machine words,
// under three idle patterns. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_psram_command_word_decoder_core;
  import psramcwd_pkg::*;

  localparam int CLK_HALF_NS    = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int PHASE_WORDS    = 82;    // counted words per random phase
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
  localparam int DRAIN_CYCLES   = 16;    // quiet time after the last result
  localparam int BANKS          = 2;
  localparam int ADDR_BITS      = 24;

  // Machines two and three: the block drops their words
  localparam logic [1:0] MACH_SPARE_A = 2'd2;
  localparam logic [1:0] MACH_SPARE_B = 2'd3;

  logic clk;
  logic rst_n;

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int open_count;

  // Stimulus-side view of each bank's transaction, so that random traffic
  // stays well formed: words in the current transaction, index of the next
  // word, command picked for it, and whether quad mode is on.
  int         txn_len   [BANKS];
  int         txn_at    [BANKS];
  logic [7:0] txn_cmd   [BANKS];
  logic       bank_quad [BANKS];

  psramcwd_in_if  in_ch ();
  psramcwd_out_if out_ch ();

  psram_command_word_decoder_core #(
    .BANK_COUNT  (BANKS),
    .ADDRESS_BITS(ADDR_BITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  psramcwd_write_checker #(
    .BANK_COUNT  (BANKS),
    .ADDRESS_BITS(ADDR_BITS)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .open_count(open_count)
  );

  initial clk = 1'b0;
  always begin
    #(CLK_HALF_NS) clk = 1'b1;
    #(CLK_HALF_NS) clk = 1'b0;
  end

  // Result side: drop ready at random with the current idle rate.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One word on in_ch. Valid stays high after the transfer so that
  // back-to-back words need no gap; the idle loop lowers it when it fires.
  task automatic send_word(input logic [31:0] w, input logic [1:0] mach, input logic bank);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.tx_word        <= w;
    in_ch.machine_number <= mach;
    in_ch.bank_select    <= bank;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Hold the sender off until every predicted result has gone out. The first
  // edge lets the checker count the word taken on the edge we just left.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  // Next word of a memory-link transaction on bank b; opens a new one with a
  // length word when the current one is complete. Lengths are kept small so
  // that a bank never sits in a long data phase.
  function automatic logic [31:0] next_bank_word(input logic b);
    logic [31:0] w;
    logic [7:0]  cmd;
    int          ndata;
    int          pick;
    if (txn_at[b] == txn_len[b]) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        cmd = CMD_WRITE;
      end else if (pick < 65) begin
        cmd = CMD_READ;
      end else if (pick < 75) begin
        cmd = CMD_QUAD;
      end else begin
        do cmd = 8'($urandom_range(255));
        while (cmd == CMD_QUAD || cmd == CMD_WRITE || cmd == CMD_READ);
      end
      txn_cmd[b] = cmd;

      if (!bank_quad[b]) begin
        // words = tx_word/32 + 2
        ndata      = $urandom_range(5);
        w          = 32'(ndata * 32 + $urandom_range(31));
        txn_len[b] = ndata + 2;
      end else if ($urandom_range(19) == 0) begin
        // (tx_word+1)*4 wraps to zero: four words, no data bytes
        w          = {2'($urandom_range(3)), 30'h3FFF_FFFF};
        txn_len[b] = 4;
      end else begin
        // words = (tx_word+1)/8 + 4; tx_word+1 must not be zero here
        ndata      = $urandom_range(5);
        w          = 32'(ndata * 8 + $urandom_range(7, (ndata == 0) ? 1 : 0) - 1);
        txn_len[b] = ndata + 4;
      end
      txn_at[b] = 1;
      return w;
    end

    if (txn_at[b] == 1) begin
      w = {txn_cmd[b], 24'($urandom)};
      if (txn_cmd[b] == CMD_READ) txn_len[b] = 3;      // read cuts it to three words
      if (txn_cmd[b] == CMD_QUAD) bank_quad[b] = 1'b1; // sticks until reset
    end else begin
      w = $urandom;  // address or data
    end
    txn_at[b]++;
    return w;
  endfunction

  // Watchdog: ends the run if nothing moves on either channel for too long.
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int   phase;
    int   counted;
    int   roll;
    logic b;

    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.tx_word        <= '0;
    in_ch.machine_number <= MACH_MEM;
    in_ch.bank_select    <= 1'b0;
    send_idle_pct         = 10;
    recv_idle_pct        <= 82;
    for (int i = 0; i < BANKS; i++) begin
      txn_len[i]   = 0;
      txn_at[i]    = 0;
      txn_cmd[i]   = '0;
      bank_quad[i] = 1'b0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // SD link gives one RX fill; machines two and three are dropped.
    send_word(32'hFFFF_FFFF, MACH_SD, 1'b1);
    send_word(32'h1234_5678, MACH_SPARE_A, 1'b0);
    send_word(32'h8765_4321, MACH_SPARE_B, 1'b1);

    // Bank 0, plain write near the top of the address space: 4 words,
    // 8 data bytes. The word at position two is data (no quad), so its
    // offset is -4 and the second data word wraps the address to zero.
    send_word(32'h0000_0040, MACH_MEM, 1'b0);
    send_word({CMD_WRITE, 24'hFF_FFFE}, MACH_MEM, 1'b0);
    send_word(32'hA1B2_C3D4, MACH_MEM, 1'b0);
    send_word(32'h0123_4567, MACH_MEM, 1'b0);

    // Bank 1: shortest transaction, which turns quad mode on.
    send_word(32'h0000_0000, MACH_MEM, 1'b1);
    send_word({CMD_QUAD, 24'h00_0000}, MACH_MEM, 1'b1);
    // Quad length with (tx_word+1)*4 wrapping to zero, then a read that
    // forces three words; position two is an address word.
    send_word(32'hFFFF_FFFF, MACH_MEM, 1'b1);
    send_word({CMD_READ, 24'h12_3456}, MACH_MEM, 1'b1);
    send_word(32'hFFFF_FFFF, MACH_MEM, 1'b1);
    // Quad write, 11 data bytes: 4 + 4 + a clamped 3.
    send_word(32'h0000_0016, MACH_MEM, 1'b1);
    send_word({CMD_WRITE, 24'h00_0000}, MACH_MEM, 1'b1);
    send_word(32'hDEAD_BEEF, MACH_MEM, 1'b1);
    send_word(32'h0000_0000, MACH_MEM, 1'b1);
    send_word(32'hFFFF_FFFF, MACH_MEM, 1'b1);
    send_word(32'h5A5A_A5A5, MACH_MEM, 1'b1);

    // Bank 0: unknown command, then a non-quad read; their data is ignored.
    send_word(32'h0000_0020, MACH_MEM, 1'b0);
    send_word(32'h0000_0000, MACH_MEM, 1'b0);
    send_word(32'hFFFF_FFFF, MACH_MEM, 1'b0);
    send_word(32'h0000_0000, MACH_MEM, 1'b0);
    send_word({CMD_READ, 24'hFF_FFFF}, MACH_MEM, 1'b0);
    send_word(32'hCAFE_F00D, MACH_MEM, 1'b0);
    bank_quad[1] = 1'b1;

    // ---- random part ----
    // Mostly well-formed transactions, banks interleaved word by word, with
    // SD-link and spare-machine words mixed in. Each phase ends with a full
    // drain so that the sender pauses on an empty pipeline.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 10;
          recv_idle_pct <= 82;
        end
        1: begin
          send_idle_pct  = 82;
          recv_idle_pct <= 10;
        end
        default: begin
          send_idle_pct  = 0;
          recv_idle_pct <= 0;
        end
      endcase
      counted = 0;
      while (counted < PHASE_WORDS) begin
        roll = $urandom_range(99);
        b    = 1'($urandom_range(1));
        if (roll < 8) begin
          send_word($urandom, MACH_SD, b);
          counted++;
        end else if (roll < 13) begin
          // dropped by the block, so not counted
          send_word($urandom, $urandom_range(1) ? MACH_SPARE_A : MACH_SPARE_B, b);
        end else begin
          send_word(next_bank_word(b), MACH_MEM, b);
          counted++;
        end
      end
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
